// File: src/mel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mel_pkg
// Shared types and constants of the motor effort limiter with friction.
// ----------------------------------------------------------------------------
package mel_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DRY_SLOPE_DEF = 65536;

  localparam logic [31:0] REDUCTION_RST = 32'h0001_0000;
  localparam logic [30:0] FULL31        = 31'h7FFF_FFFF;

  localparam int unsigned BOUND_QUO_W = 31;
  localparam int unsigned TANH_QUO_W  = 17;

  typedef enum logic [2:0] {
    REG_REDUCTION      = 3'd0,
    REG_EFFORT_LIMIT   = 3'd1,
    REG_VELOCITY_LIMIT = 3'd2,
    REG_DERATING_WIDTH = 3'd3,
    REG_VISCOUS_POS    = 3'd4,
    REG_VISCOUS_NEG    = 3'd5,
    REG_DRY_POS        = 3'd6,
    REG_DRY_NEG        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0]        reduction;
    logic [30:0]        effort_limit;
    logic [30:0]        velocity_limit;
    logic [30:0]        derating_width;
    logic signed [31:0] viscous_pos;
    logic signed [31:0] viscous_neg;
    logic signed [31:0] dry_pos;
    logic signed [31:0] dry_neg;
  } cfg_t;

endpackage

// File: src/mel_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mel_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Requires num_i < den_i * 2**QUO_W.
// ----------------------------------------------------------------------------
module mel_div #(
  parameter int unsigned NUM_W  = 47,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q    [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [QUO_W-1:0]  acc_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  acc_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = DEN_W'(num_i >> QUO_W);
      assign den_in  = den_i;
      assign acc_in  = num_i[QUO_W-1:0];
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, acc_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_q[s]  <= den_in;
        acc_q[s]  <= {acc_in[QUO_W-2:0], ge};
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = acc_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

// File: src/mel_tanh.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mel_tanh
// Signed tanh of slope times velocity: series for exp, exp(-1) steps and a
// pipelined divide, signed Q1.16 result.
// ----------------------------------------------------------------------------
module mel_tanh #(
  parameter int unsigned DRY_SLOPE = mel_pkg::DRY_SLOPE_DEF,
  parameter int unsigned SIDE_W    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] vel_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic signed [17:0] t_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int unsigned SLOPE_W   = $clog2(DRY_SLOPE + 1);
  localparam int unsigned PW        = 32 + SLOPE_W;
  localparam int unsigned N_TERMS   = 10;
  localparam int unsigned N_SER     = 3 * N_TERMS;
  localparam int unsigned N_EXP     = 15;
  localparam logic [30:0] ONE30     = 31'h4000_0000;
  localparam logic [28:0] EXP_M1    = 29'd395007542;
  localparam logic [16:0] TANH_ONE  = 17'h1_0000;

  typedef struct packed {
    logic [30:0]        term;
    logic [46:0]        prod;
    logic [30:0]        q0;
    logic signed [32:0] s;
    logic [15:0]        f;
    logic [3:0]         n;
    logic               sat;
    logic               neg;
  } series_t;

  typedef struct packed {
    logic [30:0] e;
    logic [3:0]  n;
    logic        sat;
    logic        neg;
  } exp_t;

  // slope product and range split
  logic [31:0]    av;
  logic [PW-1:0]  aprod;
  logic [63:0]    aext;

  assign av    = vel_i[31] ? 32'(-vel_i) : vel_i;
  assign aprod = PW'(av) * PW'(DRY_SLOPE);
  assign aext  = 64'(aprod);

  series_t           ser_q   [N_SER+1];
  logic              ser_v_q [N_SER+1];
  logic [SIDE_W-1:0] ser_sd_q[N_SER+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q[0] <= 1'b0;
    end else if (en_i) begin
      ser_v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ser_q[0].term <= ONE30;
      ser_q[0].prod <= '0;
      ser_q[0].q0   <= '0;
      ser_q[0].s    <= 33'(ONE30);
      ser_q[0].f    <= {aext[30:16], 1'b0};
      ser_q[0].n    <= aext[34:31];
      ser_q[0].sat  <= aext[63:35] != '0;
      ser_q[0].neg  <= vel_i[31];
      ser_sd_q[0]   <= side_i;
    end
  end

  // each series term: multiply, reciprocal multiply, correction
  for (genvar j = 1; j <= N_SER; j++) begin : g_ser
    localparam int unsigned K     = (j - 1) / 3 + 1;
    localparam int unsigned PH    = (j - 1) % 3;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

    series_t pr;
    series_t nx;

    assign pr = ser_q[j-1];

    if (PH == 0) begin : g_mul
      always_comb begin
        nx      = pr;
        nx.prod = 47'(pr.term) * 47'(pr.f);
      end
    end else if (PH == 1) begin : g_rcp
      logic [30:0] x;
      logic [63:0] m;
      assign x = pr.prod[46:16];
      assign m = 64'(x) * 64'(RECIP);
      always_comb begin
        nx      = pr;
        nx.term = x;
        nx.q0   = m[62:32];
      end
    end else begin : g_fix
      logic [31:0] r;
      logic [30:0] q;
      assign r = {1'b0, pr.term} - 32'(32'(pr.q0) * 32'(K));
      assign q = (r >= 32'(K)) ? pr.q0 + 31'd1 : pr.q0;
      always_comb begin
        nx      = pr;
        nx.term = q;
        nx.s    = (K % 2 == 1) ? pr.s - 33'(q) : pr.s + 33'(q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ser_v_q[j] <= 1'b0;
      end else if (en_i) begin
        ser_v_q[j] <= ser_v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ser_q[j]    <= nx;
        ser_sd_q[j] <= ser_sd_q[j-1];
      end
    end
  end

  // clamp, then integer part of the exponent
  exp_t              exp_q   [N_EXP+1];
  logic              exp_v_q [N_EXP+1];
  logic [SIDE_W-1:0] exp_sd_q[N_EXP+1];
  logic [30:0]       e_clamp;

  always_comb begin
    if (ser_q[N_SER].s < 0) begin
      e_clamp = '0;
    end else if (ser_q[N_SER].s > $signed(33'(ONE30))) begin
      e_clamp = ONE30;
    end else begin
      e_clamp = ser_q[N_SER].s[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_v_q[0] <= 1'b0;
    end else if (en_i) begin
      exp_v_q[0] <= ser_v_q[N_SER];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q[0].e   <= e_clamp;
      exp_q[0].n   <= ser_q[N_SER].n;
      exp_q[0].sat <= ser_q[N_SER].sat;
      exp_q[0].neg <= ser_q[N_SER].neg;
      exp_sd_q[0]  <= ser_sd_q[N_SER];
    end
  end

  for (genvar i = 1; i <= N_EXP; i++) begin : g_exp
    logic [59:0] m;
    exp_t        nx;

    assign m = 60'(exp_q[i-1].e) * 60'(EXP_M1);

    always_comb begin
      nx = exp_q[i-1];
      if (4'(i - 1) < exp_q[i-1].n) begin
        nx.e = 31'(m[59:30]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        exp_v_q[i] <= 1'b0;
      end else if (en_i) begin
        exp_v_q[i] <= exp_v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        exp_q[i]    <= nx;
        exp_sd_q[i] <= exp_sd_q[i-1];
      end
    end
  end

  // (1 - e) / (1 + e), rounded
  logic              prep_v_q;
  logic [46:0]       num_q;
  logic [31:0]       den_q;
  logic [SIDE_W+1:0] prep_sd_q;
  logic [31:0]       den_d;

  assign den_d = 32'(ONE30) + 32'(exp_q[N_EXP].e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en_i) begin
      prep_v_q <= exp_v_q[N_EXP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q     <= (47'(ONE30 - exp_q[N_EXP].e) << 16) + 47'(den_d[31:1]);
      den_q     <= den_d;
      prep_sd_q <= {exp_q[N_EXP].sat, exp_q[N_EXP].neg, exp_sd_q[N_EXP]};
    end
  end

  logic                            div_v;
  logic [mel_pkg::TANH_QUO_W-1:0]  div_q;
  logic [SIDE_W+1:0]               div_sd;

  mel_div #(
    .NUM_W (47),
    .DEN_W (32),
    .QUO_W (mel_pkg::TANH_QUO_W),
    .SIDE_W(SIDE_W + 2)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(prep_v_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (prep_sd_q),
    .valid_o(div_v),
    .quo_o  (div_q),
    .side_o (div_sd)
  );

  logic              out_v_q;
  logic signed [17:0] t_q;
  logic [SIDE_W-1:0] out_sd_q;
  logic [16:0]       mag;

  assign mag = div_sd[SIDE_W+1] ? TANH_ONE : div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= div_sd[SIDE_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      out_sd_q <= div_sd[SIDE_W-1:0];
    end
  end

  assign valid_o = out_v_q;
  assign t_o     = t_q;
  assign side_o  = out_sd_q;

endmodule

// File: src/mel_bound.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mel_bound
// Effort bounds with velocity derating and clamping of the effort command.
// ----------------------------------------------------------------------------
module mel_bound #(
  parameter int unsigned SIDE_W = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  mel_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  input  logic signed [31:0] vel_i,
  input  logic signed [31:0] cmd_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic signed [31:0] um_o,
  output logic [SIDE_W-1:0]  side_o
);

  // motor velocity
  logic signed [64:0] vprod;
  logic               s0_v_q;
  logic signed [48:0] vm_q;
  logic signed [31:0] s0_cmd_q;
  logic [SIDE_W-1:0]  s0_sd_q;

  assign vprod = $signed({1'b0, cfg_i.reduction}) * vel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vm_q     <= vprod[64:16];
      s0_cmd_q <= cmd_i;
      s0_sd_q  <= side_i;
    end
  end

  // derating numerators
  logic [30:0]        dmin;
  logic signed [49:0] dp;
  logic signed [49:0] dn;
  logic [30:0]        np_d;
  logic [30:0]        nn_d;
  logic               s1_v_q;
  logic [30:0]        np_q;
  logic [30:0]        nn_q;
  logic signed [31:0] s1_cmd_q;
  logic [SIDE_W-1:0]  s1_sd_q;

  assign dmin = (cfg_i.velocity_limit < cfg_i.derating_width) ? cfg_i.velocity_limit
                                                               : cfg_i.derating_width;
  assign dp = $signed({19'b0, cfg_i.velocity_limit}) - vm_q;
  assign dn = $signed({19'b0, cfg_i.velocity_limit}) + vm_q;

  always_comb begin
    if (dp < 0) begin
      np_d = '0;
    end else if (dp > $signed({19'b0, dmin})) begin
      np_d = dmin;
    end else begin
      np_d = dp[30:0];
    end
    if (dn < 0) begin
      nn_d = '0;
    end else if (dn > $signed({19'b0, dmin})) begin
      nn_d = dmin;
    end else begin
      nn_d = dn[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      np_q     <= np_d;
      nn_q     <= nn_d;
      s1_cmd_q <= s0_cmd_q;
      s1_sd_q  <= s0_sd_q;
    end
  end

  // limit times numerator
  logic               s2_v_q;
  logic [61:0]        pp_q;
  logic [61:0]        pn_q;
  logic signed [31:0] s2_cmd_q;
  logic [SIDE_W-1:0]  s2_sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q     <= 62'(cfg_i.effort_limit) * 62'(np_q);
      pn_q     <= 62'(cfg_i.effort_limit) * 62'(nn_q);
      s2_cmd_q <= s1_cmd_q;
      s2_sd_q  <= s1_sd_q;
    end
  end

  logic                             hi_v;
  logic                             lo_v;
  logic [mel_pkg::BOUND_QUO_W-1:0]  hi_quo;
  logic [mel_pkg::BOUND_QUO_W-1:0]  lo_quo;
  logic [SIDE_W-1:0]                hi_sd;
  logic [31:0]                      lo_sd;

  mel_div #(
    .NUM_W (62),
    .DEN_W (31),
    .QUO_W (mel_pkg::BOUND_QUO_W),
    .SIDE_W(SIDE_W)
  ) u_div_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(s2_v_q),
    .num_i  (pp_q),
    .den_i  (dmin),
    .side_i (s2_sd_q),
    .valid_o(hi_v),
    .quo_o  (hi_quo),
    .side_o (hi_sd)
  );

  mel_div #(
    .NUM_W (62),
    .DEN_W (31),
    .QUO_W (mel_pkg::BOUND_QUO_W),
    .SIDE_W(32)
  ) u_div_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(s2_v_q),
    .num_i  (pn_q),
    .den_i  (dmin),
    .side_i (s2_cmd_q),
    .valid_o(lo_v),
    .quo_o  (lo_quo),
    .side_o (lo_sd)
  );

  // bound select and clamp
  logic signed [31:0] hi;
  logic signed [31:0] lo;
  logic signed [31:0] cmd;
  logic signed [31:0] um_d;
  logic               out_v_q;
  logic signed [31:0] um_q;
  logic [SIDE_W-1:0]  out_sd_q;

  assign cmd = $signed(lo_sd);

  always_comb begin
    if (cfg_i.effort_limit == mel_pkg::FULL31) begin
      hi = 32'sh7FFF_FFFF;
      lo = 32'sh8000_0000;
    end else if (cfg_i.derating_width == '0) begin
      hi = $signed({1'b0, cfg_i.effort_limit});
      lo = -$signed({1'b0, cfg_i.effort_limit});
    end else if (dmin == '0) begin
      hi = '0;
      lo = '0;
    end else begin
      hi = $signed({1'b0, hi_quo});
      lo = -$signed({1'b0, lo_quo});
    end
    if (cmd < lo) begin
      um_d = lo;
    end else if (cmd > hi) begin
      um_d = hi;
    end else begin
      um_d = cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= hi_v & lo_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      um_q     <= um_d;
      out_sd_q <= hi_sd;
    end
  end

  assign valid_o = out_v_q;
  assign um_o    = um_q;
  assign side_o  = out_sd_q;

endmodule

// File: src/motor_effort_limit_friction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_effort_limit_friction_top
// Input transactions pass the tanh path, the bound path, the friction sum and
// the output register in that order.
// Throughput: one transaction per cycle; the pipeline stalls only while the
// output register holds an untaken result and the last stage is full.
// Reset: valid bits clear, registers return to reduction 1.0, limits full
// scale, no derating and no friction.
// ----------------------------------------------------------------------------
module motor_effort_limit_friction_top #(
  parameter int unsigned DRY_SLOPE = mel_pkg::DRY_SLOPE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] joint_velocity, [63:32] effort_command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] motor_effort, [63:32] joint_effort
);

  mel_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reduction      <= mel_pkg::REDUCTION_RST;
      cfg_q.effort_limit   <= mel_pkg::FULL31;
      cfg_q.velocity_limit <= mel_pkg::FULL31;
      cfg_q.derating_width <= '0;
      cfg_q.viscous_pos    <= '0;
      cfg_q.viscous_neg    <= '0;
      cfg_q.dry_pos        <= '0;
      cfg_q.dry_neg        <= '0;
    end else if (cfg_we_i) begin
      case (mel_pkg::cfg_reg_e'(cfg_idx_i))
        mel_pkg::REG_REDUCTION:      cfg_q.reduction      <= cfg_wdata_i;
        mel_pkg::REG_EFFORT_LIMIT:   cfg_q.effort_limit   <= cfg_wdata_i[30:0];
        mel_pkg::REG_VELOCITY_LIMIT: cfg_q.velocity_limit <= cfg_wdata_i[30:0];
        mel_pkg::REG_DERATING_WIDTH: cfg_q.derating_width <= cfg_wdata_i[30:0];
        mel_pkg::REG_VISCOUS_POS:    cfg_q.viscous_pos    <= $signed(cfg_wdata_i);
        mel_pkg::REG_VISCOUS_NEG:    cfg_q.viscous_neg    <= $signed(cfg_wdata_i);
        mel_pkg::REG_DRY_POS:        cfg_q.dry_pos        <= $signed(cfg_wdata_i);
        mel_pkg::REG_DRY_NEG:        cfg_q.dry_neg        <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  logic en;
  logic f1_v_q;
  logic out_v_q;

  assign en            = !(f1_v_q && out_v_q && !m_axis_tready);
  assign s_axis_tready = en;

  // tanh of velocity, command and velocity ride along
  logic               th_v;
  logic signed [17:0] th_t;
  logic [63:0]        th_sd;

  mel_tanh #(
    .DRY_SLOPE(DRY_SLOPE),
    .SIDE_W   (64)
  ) u_tanh (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .vel_i  ($signed(s_axis_tdata[31:0])),
    .side_i (s_axis_tdata),
    .valid_o(th_v),
    .t_o    (th_t),
    .side_o (th_sd)
  );

  logic               bd_v;
  logic signed [31:0] bd_um;
  logic [49:0]        bd_sd;

  mel_bound #(
    .SIDE_W(50)
  ) u_bound (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .valid_i(th_v),
    .vel_i  ($signed(th_sd[31:0])),
    .cmd_i  ($signed(th_sd[63:32])),
    .side_i ({th_t, th_sd[31:0]}),
    .valid_o(bd_v),
    .um_o   (bd_um),
    .side_o (bd_sd)
  );

  // friction products
  logic signed [31:0] vel;
  logic signed [17:0] tq;
  logic               vpos;
  logic signed [31:0] csel;
  logic signed [31:0] dsel;
  logic signed [64:0] rprod;
  logic signed [63:0] cprod;
  logic signed [49:0] dprod;

  assign vel   = $signed(bd_sd[31:0]);
  assign tq    = $signed(bd_sd[49:32]);
  assign vpos  = !vel[31] && (vel != '0);
  assign csel  = vpos ? cfg_q.viscous_pos : cfg_q.viscous_neg;
  assign dsel  = vpos ? cfg_q.dry_pos : cfg_q.dry_neg;
  assign rprod = $signed({1'b0, cfg_q.reduction}) * bd_um;
  assign cprod = csel * vel;
  assign dprod = dsel * tq;

  logic               f0_v_q;
  logic signed [48:0] rt_q;
  logic signed [47:0] vt_q;
  logic signed [33:0] dt_q;
  logic signed [31:0] f0_um_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
    end else if (en) begin
      f0_v_q <= bd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q    <= rprod[64:16];
      vt_q    <= cprod[63:16];
      dt_q    <= dprod[49:16];
      f0_um_q <= bd_um;
    end
  end

  // sum and saturate
  logic signed [50:0] sum;
  logic signed [31:0] jt_d;
  logic signed [31:0] f1_jt_q;
  logic signed [31:0] f1_um_q;

  assign sum = 51'(rt_q) + 51'(vt_q) + 51'(dt_q);

  always_comb begin
    if ((&sum[50:31]) || !(|sum[50:31])) begin
      jt_d = sum[31:0];
    end else if (sum[50]) begin
      jt_d = 32'sh8000_0000;
    end else begin
      jt_d = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= f0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_jt_q <= jt_d;
      f1_um_q <= f0_um_q;
    end
  end

  // output register
  logic [63:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_data_q <= {f1_jt_q, f1_um_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: dv/mel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mel_checker
// Watches the input and output streams of the effort limiter, predicts the
// limited motor effort and the joint effort with friction for every accepted
// input transaction, and compares each output transaction in order.
// ----------------------------------------------------------------------------
module mel_checker
  import mel_pkg::*;
#(
  parameter int unsigned DRY_SLOPE = DRY_SLOPE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);

  cfg_t        regs;
  logic [63:0] effort_q[$];

  function automatic longint shr16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint tanh_q16(longint unsigned a);
    longint unsigned y, n, f, term, e, den;
    longint          s;
    if (a >= (64'd8 << 16)) return 65536;
    y = a << 1;
    n = y >> 16;
    f = y & 64'hFFFF;
    term = 64'd1 << 30;
    s = longint'(term);
    for (int k = 1; k <= 10; k++) begin
      term = (term * f) / (longint'(k) << 16);
      if (k % 2) s -= longint'(term);
      else s += longint'(term);
    end
    e = (s < 0) ? 0 : longint'(s);
    if (e > (64'd1 << 30)) e = 64'd1 << 30;
    for (longint unsigned k = 0; k < n; k++) e = (e * 64'd395007542) >> 30;
    den = (64'd1 << 30) + e;
    return longint'(((((64'd1 << 30) - e) << 16) + (den >> 1)) / den);
  endfunction

  function automatic logic [63:0] limit_effort(cfg_t c, logic [63:0] din);
    longint v, cmd, r, vm, lo, hi, um, jt, t, visc, dry, lim, vl, d, np, nn;
    longint unsigned av;
    v = longint'(signed'(din[31:0]));
    cmd = longint'(signed'(din[63:32]));
    r = longint'({32'd0, c.reduction});
    vm = shr16(r * v);
    lo = -64'sd2147483648;
    hi = 64'sd2147483647;
    if (c.effort_limit != FULL31) begin
      lim = longint'(c.effort_limit);
      lo = -lim;
      hi = lim;
      if (c.derating_width != 0) begin
        vl = longint'(c.velocity_limit);
        d = longint'(c.derating_width);
        if (vl < d) d = vl;
        if (d == 0) begin
          lo = 0;
          hi = 0;
        end else begin
          np = vl - vm;
          np = np < 0 ? 0 : (np > d ? d : np);
          nn = vl + vm;
          nn = nn < 0 ? 0 : (nn > d ? d : nn);
          hi = (lim * np) / d;
          lo = -((lim * nn) / d);
        end
      end
    end
    um = cmd < lo ? lo : (cmd > hi ? hi : cmd);
    av = v < 0 ? -v : v;
    t = tanh_q16((longint'(DRY_SLOPE) * av) >> 16);
    if (v < 0) t = -t;
    if (v > 0) begin
      visc = shr16(longint'(c.viscous_pos) * v);
      dry = shr16(longint'(c.dry_pos) * t);
    end else begin
      visc = shr16(longint'(c.viscous_neg) * v);
      dry = shr16(longint'(c.dry_neg) * t);
    end
    jt = shr16(r * um) + visc + dry;
    if (jt < -64'sd2147483648) jt = -64'sd2147483648;
    if (jt > 64'sd2147483647) jt = 64'sd2147483647;
    return {jt[31:0], um[31:0]};
  endfunction

  assign pending_o = effort_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      regs <= '{REDUCTION_RST, FULL31, FULL31, 31'd0, 0, 0, 0, 0};
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_REDUCTION:      regs.reduction <= cfg_wdata_i;
          REG_EFFORT_LIMIT:   regs.effort_limit <= cfg_wdata_i[30:0];
          REG_VELOCITY_LIMIT: regs.velocity_limit <= cfg_wdata_i[30:0];
          REG_DERATING_WIDTH: regs.derating_width <= cfg_wdata_i[30:0];
          REG_VISCOUS_POS:    regs.viscous_pos <= cfg_wdata_i;
          REG_VISCOUS_NEG:    regs.viscous_neg <= cfg_wdata_i;
          REG_DRY_POS:        regs.dry_pos <= cfg_wdata_i;
          REG_DRY_NEG:        regs.dry_neg <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) effort_q.push_back(limit_effort(regs, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (effort_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected output transaction %h", m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          want = effort_q.pop_front();
          if (want !== m_axis_tdata) begin
            if (errors_o < 10)
              $display("mismatch motor_effort exp %h got %h, joint_effort exp %h got %h",
                       want[31:0], m_axis_tdata[31:0], want[63:32], m_axis_tdata[63:32]);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/tb_motor_effort_limit_friction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_effort_limit_friction_top
// Drives directed and random velocity/command pairs through several register
// settings with bursty input and stalling output; the checker compares.
// ----------------------------------------------------------------------------
module tb_motor_effort_limit_friction_top;
  import mel_pkg::*;

  localparam int LATENCY = 104;
  localparam int LIMIT   = 400000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  int          errors, pending, cycles;

  motor_effort_limit_friction_top uut (.*);

  mel_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output stall pattern: phases of free flow, light and heavy stalls
  int stall_mode;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  int burst_left;

  task automatic send_item(logic [31:0] vel, logic [31:0] cmd);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cmd, vel};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return {{16{1'b0}}, 16'($urandom)} ^ ({32{$urandom_range(0, 1) == 1}});
      3: return 32'h8000_0000 | $urandom_range(0, 3);
      4: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic set_regs(logic [31:0] red, lim, vl, w, vp, vn, dp, dn);
    write_reg(REG_REDUCTION, red);
    write_reg(REG_EFFORT_LIMIT, lim);
    write_reg(REG_VELOCITY_LIMIT, vl);
    write_reg(REG_DERATING_WIDTH, w);
    write_reg(REG_VISCOUS_POS, vp);
    write_reg(REG_VISCOUS_NEG, vn);
    write_reg(REG_DRY_POS, dp);
    write_reg(REG_DRY_NEG, dn);
  endtask

  task automatic run_random(int n);
    repeat (n) send_item(rand_val(), rand_val());
  endtask

  initial begin
    logic [31:0] edge_v[8];
    rst_ni = 0;
    cycles = 0;
    stall_mode = 0;
    burst_left = 0;
    cfg_we_i = 0;
    cfg_idx_i = REG_REDUCTION;
    cfg_wdata_i = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    m_axis_tready = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset registers, then limited with derating and friction
    edge_v = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0001_0000, 32'hFFFF_0000, 32'h0008_0000};
    foreach (edge_v[i]) send_item(edge_v[i], edge_v[7 - i]);
    drain();
    set_regs(32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 32'h0001_0000,
             32'hFFFF_8000, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFF_C000);
    foreach (edge_v[i]) send_item(edge_v[i], edge_v[i]);
    send_item(32'h0002_0000, 32'h7FFF_FFFF);
    send_item(32'hFFFE_0000, 32'h8000_0000);
    drain();
    // zero velocity limit with derating on, extreme registers
    set_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    foreach (edge_v[i]) send_item(edge_v[i], edge_v[7 - i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(REDUCTION_RST, FULL31, FULL31, 0, 0, 0, 0, 0);
        1: set_regs(0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h0001_0000, 32'h7FFF_FFFF, 32'h1, 32'h1);
        default: set_regs($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0100_0000),
                          $urandom_range(0, 32'h0080_0000), $urandom_range(0, 32'h0040_0000),
                          -$urandom_range(0, 32'h0004_0000), -$urandom_range(0, 32'h0004_0000),
                          -$urandom_range(0, 32'h0100_0000), $urandom);
      endcase
      run_random(240);
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
